FILE: hw/rtl/free_memory_map_merge_top_macros.svh
// Assertion macros shared by the checker of the free memory map merge block.
// No dependencies; included by the checker file.
`ifndef FREE_MEMORY_MAP_MERGE_TOP_MACROS_SVH
`define FREE_MEMORY_MAP_MERGE_TOP_MACROS_SVH

// clocked assertion, held off during reset
`define FMM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked assertion, also checked during reset
`define FMM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/fmm_pkg.sv
// Package of the free memory map merge block: constants and state type.
// No dependencies; used by free_memory_map_merge_top and the testbench files.
package fmm_pkg;
	localparam int MAX_ENTRIES = 32;
	localparam int PAGE_SHIFT  = 12;
	localparam int MAX_RESULTS = 32;
	localparam int NRES_W      = $clog2(MAX_RESULTS + 1);
	localparam logic [63:0] ALL_ONES = ~64'd0;

	localparam logic CFG_USABLE_TYPE = 1'b0;
	localparam logic CFG_REQ_ATTR    = 1'b1;

	typedef enum logic [2:0] {
		S_LOAD,
		S_CHECK,
		S_MIN,
		S_GROW,
		S_TRIM,
		S_FINAL
	} state_t;
endpackage

FILE: hw/rtl/free_memory_map_merge_top.sv
// Top level of the free memory map merge block.
// Depends on fmm_pkg and fmm_ram.

// Entries are taken one per cycle while loading; usable ones go to a table RAM of
// base and saturated end. After the entry flagged last_entry the input stalls and the
// merge walks the table through the RAM read port, one entry per cycle: for each
// region one pass for the lowest base at or above the cursor and one pass to grow it;
// an output stall can hold the trim and final steps. Results leave through an output register.
module free_memory_map_merge_top #(
	parameter int MAX_ENTRIES = fmm_pkg::MAX_ENTRIES,
	parameter int PAGE_SHIFT  = fmm_pkg::PAGE_SHIFT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] entry_base,
	input  logic [63:0] entry_length,
	input  logic [31:0] entry_type,
	input  logic [31:0] entry_attribute,
	input  logic        last_entry,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] region_base,
	output logic [63:0] region_size,
	output logic        region_valid,
	output logic        last_region,
	output logic        table_overflow
);
	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam logic [63:0] PMASK = (64'd1 << PAGE_SHIFT) - 64'd1;
	localparam int NW = fmm_pkg::NRES_W;

	fmm_pkg::state_t state_q, state_d;

	logic [31:0] usable_type_q, req_attr_q;
	logic [CW-1:0] cnt_q, issue_q;
	logic ovf_q, vld_s1, found_q, pend_vld_q;
	logic [63:0] mem_end_q, cursor_q, start_q, rend_q, pend_base_q, pend_size_q;
	logic [NW-1:0] nres_q;
	logic out_vld_q, out_rv_q, out_last_q, out_ovf_q;
	logic [63:0] out_base_q, out_size_q;

	logic accept, usable, wr_en, rd_en, pass_done, out_free, emit;
	logic [63:0] new_end, lo, hi, rd_base, rd_end;
	logic [127:0] rdata;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != fmm_pkg::S_LOAD);
	assign usable   = (entry_type == usable_type_q) && (entry_attribute == req_attr_q);
	assign wr_en    = accept && usable && (cnt_q < CW'(MAX_ENTRIES));
	assign new_end  = (entry_base + entry_length < entry_base) ? fmm_pkg::ALL_ONES
	                                                           : entry_base + entry_length;
	assign rd_en    = ((state_q == fmm_pkg::S_MIN) || (state_q == fmm_pkg::S_GROW))
	                  && (issue_q < cnt_q);
	assign pass_done = !rd_en && !vld_s1;
	assign rd_base  = rdata[127:64];
	assign rd_end   = rdata[63:0];
	assign out_free = !out_vld_q || !out_stall;

	fmm_ram #(.WIDTH(128), .DEPTH(MAX_ENTRIES), .AW(AW)) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (cnt_q[AW-1:0]),
		.wdata ({entry_base, new_end}),
		.raddr (issue_q[AW-1:0]),
		.rdata (rdata)
	);

	always_comb begin
		hi = rend_q & ~PMASK;
		lo = start_q;
		if ((start_q & PMASK) != 64'd0) begin
			if (start_q > (fmm_pkg::ALL_ONES - PMASK)) begin
				lo = fmm_pkg::ALL_ONES;
				hi = 64'd0;
			end else begin
				lo = (start_q | PMASK) + 64'd1;
			end
		end
		emit = (hi > lo) && (nres_q < NW'(fmm_pkg::MAX_RESULTS));
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			fmm_pkg::S_LOAD: begin
				if (accept && last_entry) state_d = fmm_pkg::S_CHECK;
			end
			fmm_pkg::S_CHECK: begin
				state_d = (cursor_q < mem_end_q) ? fmm_pkg::S_MIN : fmm_pkg::S_FINAL;
			end
			fmm_pkg::S_MIN: begin
				if (pass_done) state_d = found_q ? fmm_pkg::S_GROW : fmm_pkg::S_FINAL;
			end
			fmm_pkg::S_GROW: begin
				if (pass_done) state_d = fmm_pkg::S_TRIM;
			end
			fmm_pkg::S_TRIM: begin
				if (!(emit && pend_vld_q) || out_free) begin
					state_d = (rend_q == fmm_pkg::ALL_ONES) ? fmm_pkg::S_FINAL
					                                        : fmm_pkg::S_CHECK;
				end
			end
			fmm_pkg::S_FINAL: begin
				if (out_free) state_d = fmm_pkg::S_LOAD;
			end
			default: state_d = fmm_pkg::S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fmm_pkg::S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			usable_type_q <= 32'd1;
			req_attr_q    <= 32'd1;
			cnt_q         <= '0;
			ovf_q         <= 1'b0;
			mem_end_q     <= '0;
			cursor_q      <= '0;
			issue_q       <= '0;
			vld_s1        <= 1'b0;
			found_q       <= 1'b0;
			pend_vld_q    <= 1'b0;
			nres_q        <= '0;
			out_vld_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == fmm_pkg::CFG_USABLE_TYPE) usable_type_q <= cfg_data;
				else req_attr_q <= cfg_data;
			end
			if (out_vld_q && !out_stall) out_vld_q <= 1'b0;
			vld_s1 <= rd_en;
			if (rd_en) issue_q <= issue_q + CW'(1);
			case (state_q)
				fmm_pkg::S_LOAD: begin
					if (accept && usable) begin
						if (wr_en) begin
							cnt_q <= cnt_q + CW'(1);
							if (new_end > mem_end_q) mem_end_q <= new_end;
						end else begin
							ovf_q <= 1'b1;
						end
					end
					cursor_q   <= '0;
					pend_vld_q <= 1'b0;
					nres_q     <= '0;
				end
				fmm_pkg::S_CHECK: begin
					issue_q <= '0;
					found_q <= 1'b0;
				end
				fmm_pkg::S_MIN: begin
					if (vld_s1 && (rd_base >= cursor_q) && (!found_q || rd_base < start_q)) begin
						start_q <= rd_base;
						found_q <= 1'b1;
					end
					if (pass_done) begin
						issue_q <= '0;
						rend_q  <= start_q;
					end
				end
				fmm_pkg::S_GROW: begin
					if (vld_s1 && (rd_base <= rend_q) && (rd_end >= rend_q)) rend_q <= rd_end;
				end
				fmm_pkg::S_TRIM: begin
					if (!(emit && pend_vld_q) || out_free) begin
						if (emit) begin
							if (pend_vld_q) begin
								out_vld_q  <= 1'b1;
								out_base_q <= pend_base_q;
								out_size_q <= pend_size_q;
								out_rv_q   <= 1'b1;
								out_last_q <= 1'b0;
								out_ovf_q  <= ovf_q;
							end
							pend_vld_q  <= 1'b1;
							pend_base_q <= lo;
							pend_size_q <= hi - lo;
							nres_q      <= nres_q + NW'(1);
						end
						cursor_q <= rend_q + 64'd1;
					end
				end
				fmm_pkg::S_FINAL: begin
					if (out_free) begin
						out_vld_q  <= 1'b1;
						out_base_q <= pend_vld_q ? pend_base_q : 64'd0;
						out_size_q <= pend_vld_q ? pend_size_q : 64'd0;
						out_rv_q   <= pend_vld_q;
						out_last_q <= 1'b1;
						out_ovf_q  <= ovf_q;
						cnt_q      <= '0;
						ovf_q      <= 1'b0;
						mem_end_q  <= '0;
						pend_vld_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid      = out_vld_q;
	assign region_base    = out_base_q;
	assign region_size    = out_size_q;
	assign region_valid   = out_rv_q;
	assign last_region    = out_last_q;
	assign table_overflow = out_ovf_q;
endmodule

FILE: hw/rtl/fmm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module fmm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: hw/rtl/fmm_checker.sv
// Port-level checker for free_memory_map_merge_top, bound to it below.
// Depends on free_memory_map_merge_top_macros.svh.
`include "free_memory_map_merge_top_macros.svh"

module fmm_port_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        last_entry,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] region_base,
	input logic [63:0] region_size,
	input logic        region_valid,
	input logic        last_region
);
	`FMM_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(region_base) && $stable(region_size), "stalled request changed")
	`FMM_ASSERT(a_last_stalls, in_valid && !in_stall && last_entry |=> in_stall, "input not stalled after last entry")
	`FMM_ASSERT(a_empty_result, out_valid && !region_valid |-> last_region && region_base == 64'd0 && region_size == 64'd0, "empty result malformed")
	`FMM_ASSERT(a_nonzero_size, out_valid && region_valid |-> region_size != 64'd0, "region of zero size")
	`FMM_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !out_valid && !in_stall, "not idle in reset")
endmodule

bind free_memory_map_merge_top fmm_port_checker u_fmm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.last_entry   (last_entry),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.region_base  (region_base),
	.region_size  (region_size),
	.region_valid (region_valid),
	.last_region  (last_region)
);

FILE: tb/sv/fmm_checker.sv
// Checker of the free memory map merge block: watches both channels, predicts the
// free regions of each table and compares every result with the oldest prediction.
// Depends on fmm_pkg; instantiated beside the block by the testbench top.
`timescale 1ns / 1ps

module fmm_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [63:0] entry_base,
	input  logic [63:0] entry_length,
	input  logic [31:0] entry_type,
	input  logic [31:0] entry_attribute,
	input  logic        last_entry,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [63:0] region_base,
	input  logic [63:0] region_size,
	input  logic        region_valid,
	input  logic        last_region,
	input  logic        table_overflow,
	output int          fail_count,
	output int          pending
);
	import fmm_pkg::*;

	typedef struct packed {
		logic [63:0] base;
		logic [63:0] size;
		logic        valid;
		logic        last;
		logic        ovf;
	} region_t;

	region_t     region_q[$];
	logic [63:0] tbl_base[MAX_ENTRIES];
	logic [63:0] tbl_len[MAX_ENTRIES];
	int          tbl_count;
	logic        tbl_ovf;
	logic [31:0] usable_type;
	logic [31:0] req_attr;

	assign pending = region_q.size();

	function automatic logic [63:0] sat_end(int i);
		logic [63:0] e;
		e = tbl_base[i] + tbl_len[i];
		return (e < tbl_base[i]) ? ALL_ONES : e;
	endfunction

	task automatic merge_table();
		logic [63:0] pmask, mem_end, cursor, start, rend, lo, hi, e;
		logic        found;
		int          n;
		region_t     r;
		pmask   = (64'd1 << PAGE_SHIFT) - 64'd1;
		mem_end = 0;
		n       = 0;
		for (int i = 0; i < tbl_count; i++) begin
			e = sat_end(i);
			if (e > mem_end)
				mem_end = e;
		end
		cursor = 0;
		while (cursor < mem_end) begin
			found = 0;
			start = ALL_ONES;
			for (int i = 0; i < tbl_count; i++)
				if (tbl_base[i] >= cursor && (!found || tbl_base[i] < start)) begin
					start = tbl_base[i];
					found = 1;
				end
			if (!found)
				break;
			rend = start;
			for (int i = 0; i < tbl_count; i++) begin
				e = sat_end(i);
				if (tbl_base[i] <= rend && e >= rend)
					rend = e;
			end
			hi = rend & ~pmask;
			if ((start & pmask) == 0)
				lo = start;
			else if (start > ALL_ONES - pmask) begin
				lo = ALL_ONES;
				hi = 0;
			end else
				lo = (start | pmask) + 64'd1;
			if (hi > lo && n < MAX_RESULTS) begin
				r = '{base: lo, size: hi - lo, valid: 1'b1, last: 1'b0, ovf: tbl_ovf};
				region_q.push_back(r);
				n++;
			end
			if (rend == ALL_ONES)
				break;
			cursor = rend + 64'd1;
		end
		if (n == 0)
			region_q.push_back('{base: 0, size: 0, valid: 1'b0, last: 1'b1, ovf: tbl_ovf});
		else
			region_q[$].last = 1'b1;
		tbl_count = 0;
		tbl_ovf   = 0;
	endtask

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		region_t w;
		if (!arst_n) begin
			region_q.delete();
			tbl_count   = 0;
			tbl_ovf     = 0;
			usable_type = 32'd1;
			req_attr    = 32'd1;
			fail_count  = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (region_q.size() == 0)
					report("unexpected region", region_base, 0);
				else begin
					w = region_q.pop_front();
					if (region_base !== w.base)
						report("region_base", region_base, w.base);
					if (region_size !== w.size)
						report("region_size", region_size, w.size);
					if (region_valid !== w.valid)
						report("region_valid", region_valid, w.valid);
					if (last_region !== w.last)
						report("last_region", last_region, w.last);
					if (table_overflow !== w.ovf)
						report("table_overflow", table_overflow, w.ovf);
				end
			end
			if (in_valid && !in_stall) begin
				if (entry_type == usable_type && entry_attribute == req_attr) begin
					if (tbl_count < MAX_ENTRIES) begin
						tbl_base[tbl_count] = entry_base;
						tbl_len[tbl_count]  = entry_length;
						tbl_count++;
					end else
						tbl_ovf = 1;
				end
				if (last_entry)
					merge_table();
			end
			if (cfg_we) begin
				if (cfg_index == CFG_USABLE_TYPE)
					usable_type = cfg_data;
				else
					req_attr = cfg_data;
			end
		end
	end
endmodule

FILE: tb/sv/testbench.sv
// Testbench top of the free memory map merge block: clock, reset, register writes,
// memory-map tables as requests, random output stall and the verdict.
// Depends on fmm_pkg, free_memory_map_merge_top and fmm_checker.
`timescale 1ns / 1ps

module testbench;
	import fmm_pkg::*;

	localparam int WATCHDOG = 20000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic        cfg_index = 0;
	logic [31:0] cfg_data = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [63:0] entry_base = 0;
	logic [63:0] entry_length = 0;
	logic [31:0] entry_type = 0;
	logic [31:0] entry_attribute = 0;
	logic        last_entry = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [63:0] region_base, region_size;
	logic        region_valid, last_region, table_overflow;
	int          fail_count, pending;
	int          idle_cycles = 0;
	logic [31:0] cur_type = 1, cur_attr = 1;

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	free_memory_map_merge_top dut (.*);
	fmm_checker chk (.*);

	always @(posedge clk)
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;

	always @(posedge clk)
		if (idle_cycles >= WATCHDOG) begin
			$display("watchdog expired");
			$display("** free_memory_map_merge_top: FAILED **");
			$finish;
		end

	// random receiver stall, redrawn after each accepted result
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
			if ($urandom_range(0, 7) == 0)
				gap = 0;
			out_stall = gap != 0;
			repeat (gap)
				@(negedge clk);
			out_stall = 0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// stall is stable from one rising edge to the next, so it is checked at the falling edge
	task automatic send(logic [63:0] b, logic [63:0] l, logic [31:0] t, logic [31:0] a,
		logic last);
		int gap;
		gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 16);
		repeat (gap)
			@(negedge clk);
		in_valid        = 1;
		entry_base      = b;
		entry_length    = l;
		entry_type      = t;
		entry_attribute = a;
		last_entry      = last;
		while (in_stall)
			@(negedge clk);
		@(negedge clk);
		in_valid = 0;
	endtask

	task automatic usable(logic [63:0] b, logic [63:0] l, logic last);
		send(b, l, cur_type, cur_attr, last);
	endtask

	task automatic drain();
		while (pending != 0)
			@(negedge clk);
		repeat (300)
			@(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] v);
		drain();
		cfg_we    <= 1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(negedge clk);
		cfg_we <= 0;
		if (idx == CFG_USABLE_TYPE)
			cur_type = v;
		else
			cur_attr = v;
	endtask

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	task automatic random_table();
		int          n;
		logic [63:0] b, l, span;
		logic [31:0] t, a;
		n    = $urandom_range(0, 9) == 0 ? $urandom_range(30, 36) : $urandom_range(1, 8);
		span = $urandom_range(0, 3) == 0 ? ALL_ONES : (64'd1 << $urandom_range(14, 24));
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 5))
				0: begin
					b = rnd64();
					l = rnd64();
				end
				1: begin
					b = ALL_ONES - $urandom_range(0, 20000);
					l = $urandom_range(0, 40000);
				end
				default: begin
					b = rnd64() % span;
					l = $urandom_range(0, 5) == 0 ? 0 : $urandom_range(1, 65536);
				end
			endcase
			t = $urandom_range(0, 4) == 0 ? $urandom : cur_type;
			a = $urandom_range(0, 4) == 0 ? $urandom : cur_attr;
			send(b, l, t, a, i == n - 1);
		end
	endtask

	initial begin
		repeat (6)
			@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// no usable entry, then a non-usable lone last entry
		send(64'h1000, 64'h1000, 32'd2, 32'd1, 1);
		// aligned, unaligned, adjoining and overlapping
		usable(64'h0, 64'h3000, 0);
		usable(64'h3000, 64'h2000, 0);
		usable(64'h8123, 64'h4000, 0);
		usable(64'h9000, 64'h10, 0);
		usable(64'h20000, 64'h0, 0);
		send(64'h40000, 64'h4000, 32'd1, 32'd0, 1);
		// end saturation, region at the top, round-up past the top
		usable(ALL_ONES - 64'h5000, ALL_ONES, 0);
		usable(ALL_ONES - 64'h10, 64'h5, 0);
		usable(64'h0, 64'h800, 1);
		usable(ALL_ONES, 64'h1, 1);
		usable(ALL_ONES - 64'h1001, 64'h2, 1);
		// table overflow, and as many regions as the result limit
		for (int i = 0; i < 35; i++)
			usable(i * 64'h2000, 64'h1000, i == 34);

		write_reg(CFG_USABLE_TYPE, 32'hFFFF_FFFF);
		write_reg(CFG_REQ_ATTR, 32'h0);
		usable(64'h1000, 64'h1000, 0);
		send(64'h5000, 64'h1000, 32'd1, 32'd1, 1);
		write_reg(CFG_USABLE_TYPE, 32'h0);
		write_reg(CFG_REQ_ATTR, 32'hFFFF_FFFF);
		usable(rnd64(), rnd64(), 1);

		for (int k = 0; k < 29; k++) begin
			if (k % 12 == 11) begin
				write_reg(CFG_USABLE_TYPE, $urandom);
				write_reg(CFG_REQ_ATTR, $urandom);
			end
			random_table();
		end
		write_reg(CFG_USABLE_TYPE, 32'd1);
		write_reg(CFG_REQ_ATTR, 32'd1);
		drain();
		if (fail_count == 0)
			$display("** free_memory_map_merge_top: PASSED **");
		else
			$display("** free_memory_map_merge_top: FAILED **");
		$finish;
	end
endmodule
